// File: design/crom_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cartridge ROM address pattern block.
package crom_pkg;

    localparam int unsigned ADDR_W = 21;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned DATA_W = 32;

    localparam logic [HALF_W-1:0] MASK_AAAA = 16'hAAAA;
    localparam logic [HALF_W-1:0] MASK_5555 = 16'h5555;
    localparam logic [HALF_W-1:0] MASK_F0F0 = 16'hF0F0;
    localparam logic [HALF_W-1:0] MASK_0F0F = 16'h0F0F;
    localparam logic [HALF_W-1:0] MASK_FF00 = 16'hFF00;
    localparam logic [HALF_W-1:0] MASK_00FF = 16'h00FF;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_HALF = 2'd1,
        CMD_WORD = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_INC  = 2'd1,
        ADJ_DEC  = 2'd2
    } t_adj;

    typedef struct packed {
        logic [HALF_W-1:0] value;
        t_adj              adj;
    } t_base;

endpackage

// File: design/crom_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and the read data.
interface crom_in_if;
    logic                        valid;
    logic                        ready;
    logic [crom_pkg::ADDR_W-1:0] address;
    logic [1:0]                  command;

    modport source (output valid, output address, output command, input ready);
    modport sink (input valid, input address, input command, output ready);
endinterface

interface crom_out_if;
    logic                        valid;
    logic                        ready;
    logic [crom_pkg::DATA_W-1:0] read_value;

    modport source (output valid, output read_value, input ready);
    modport sink (input valid, input read_value, output ready);
endinterface

// File: design/crom_base.sv
`timescale 1ns / 1ps
// Region decoder that forms the unadjusted pattern and selects its plus or minus one step.
module crom_base (
    input  logic [crom_pkg::ADDR_W-1:0] i_address,
    output crom_pkg::t_base             o_base
);
    logic [4:0]                  region;
    logic [crom_pkg::HALF_W-1:0] lo;
    logic [crom_pkg::HALF_W-1:0] half;
    logic [crom_pkg::HALF_W-1:0] mix;
    logic [crom_pkg::HALF_W-2:0] lo_sh;

    assign region = i_address[20:16];
    assign lo     = i_address[15:0];
    assign half   = i_address[16:1];
    assign lo_sh  = lo[15:1];
    assign mix    = {i_address[1:0] == 2'd2, i_address[16], lo[15:2]};

    always_comb begin
        o_base.adj = crom_pkg::ADJ_NONE;
        unique case (region) inside
            5'h00, 5'h01: o_base.value = half;
            5'h02: o_base.value = lo;
            5'h03: begin
                o_base.value = lo;
                o_base.adj   = crom_pkg::ADJ_INC;
            end
            5'h04: o_base.value = ~lo;
            5'h05: begin
                o_base.value = ~lo;
                o_base.adj   = crom_pkg::ADJ_DEC;
            end
            5'h06: o_base.value = lo ^ crom_pkg::MASK_AAAA;
            5'h07: begin
                o_base.value = lo ^ crom_pkg::MASK_AAAA;
                o_base.adj   = crom_pkg::ADJ_INC;
            end
            5'h08: o_base.value = lo ^ crom_pkg::MASK_5555;
            5'h09: begin
                o_base.value = lo ^ crom_pkg::MASK_5555;
                o_base.adj   = crom_pkg::ADJ_DEC;
            end
            5'h0A, 5'h0B: o_base.value = mix;
            5'h0C, 5'h0D: o_base.value = ~mix;
            5'h0E, 5'h0F: o_base.value = mix ^ crom_pkg::MASK_AAAA;
            5'h10, 5'h11: o_base.value = mix ^ crom_pkg::MASK_5555;
            5'h12: o_base.value = {1'b1, ~lo_sh};
            5'h13: o_base.value = {1'b0, ~lo_sh};
            5'h14, 5'h15: o_base.value = half ^ crom_pkg::MASK_AAAA;
            5'h16, 5'h17: o_base.value = half ^ crom_pkg::MASK_5555;
            5'h18, 5'h19: o_base.value = half ^ crom_pkg::MASK_F0F0;
            5'h1A, 5'h1B: o_base.value = half ^ crom_pkg::MASK_0F0F;
            5'h1C, 5'h1D: o_base.value = half ^ crom_pkg::MASK_FF00;
            default: o_base.value = half ^ crom_pkg::MASK_00FF;
        endcase
    end
endmodule

// File: design/crom_adjust.sv
`timescale 1ns / 1ps
// Applies the wrapping plus or minus one step to a decoded pattern.
module crom_adjust (
    input  crom_pkg::t_base             i_base,
    output logic [crom_pkg::HALF_W-1:0] o_pattern
);
    always_comb begin
        unique case (i_base.adj)
            crom_pkg::ADJ_INC: o_pattern = i_base.value + 16'd1;
            crom_pkg::ADJ_DEC: o_pattern = i_base.value - 16'd1;
            default:           o_pattern = i_base.value;
        endcase
    end
endmodule

// File: design/cart_rom_address_pattern.sv
`timescale 1ns / 1ps
// Throughput is one transaction per cycle while the output is ready, through four register stages:
// request and address+2, region decode, adjust, and width formatting.
// Each stage takes new data whenever it is empty or its successor moves on.
// Reset clears only the stage valid bits; the data registers are not reset.
module cart_rom_address_pattern (
    input  logic              i_clk,
    input  logic              i_rst_n,
    crom_in_if.sink           i_in,
    crom_out_if.source        o_out
);
    logic r_v0, r_v1, r_v2, r_v3;
    logic ld0, ld1, ld2, ld3;

    logic [crom_pkg::ADDR_W-1:0] r_addr0, r_addr2_0;
    crom_pkg::t_cmd              r_cmd0, r_cmd1, r_cmd2;
    logic                        r_odd1, r_odd2;
    crom_pkg::t_base             r_base_a1, r_base_b1;
    logic [crom_pkg::HALF_W-1:0] r_pat_a2, r_pat_b2;
    logic [crom_pkg::DATA_W-1:0] r_data3;

    crom_pkg::t_base             base_a, base_b;
    logic [crom_pkg::HALF_W-1:0] pat_a, pat_b;
    logic [crom_pkg::DATA_W-1:0] n_data3;

    assign ld3 = !r_v3 || o_out.ready;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign ld0 = !r_v0 || ld1;

    assign i_in.ready       = ld0;
    assign o_out.valid      = r_v3;
    assign o_out.read_value = r_data3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld0) r_v0 <= i_in.valid;
            if (ld1) r_v1 <= r_v0;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
        end
    end

    crom_base u_base_a (.i_address(r_addr0),   .o_base(base_a));
    crom_base u_base_b (.i_address(r_addr2_0), .o_base(base_b));

    crom_adjust u_adjust_a (.i_base(r_base_a1), .o_pattern(pat_a));
    crom_adjust u_adjust_b (.i_base(r_base_b1), .o_pattern(pat_b));

    always_comb begin
        unique case (r_cmd2)
            crom_pkg::CMD_BYTE: n_data3 = r_odd2 ? {24'd0, r_pat_a2[7:0]}
                                                 : {24'd0, r_pat_a2[15:8]};
            crom_pkg::CMD_HALF: n_data3 = {16'd0, r_pat_a2};
            crom_pkg::CMD_WORD: n_data3 = {r_pat_a2, r_pat_b2};
            default:            n_data3 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_addr0   <= i_in.address;
            r_addr2_0 <= i_in.address + 21'd2;
            r_cmd0    <= crom_pkg::t_cmd'(i_in.command);
        end
        if (ld1) begin
            r_base_a1 <= base_a;
            r_base_b1 <= base_b;
            r_cmd1    <= r_cmd0;
            r_odd1    <= r_addr0[0];
        end
        if (ld2) begin
            r_pat_a2 <= pat_a;
            r_pat_b2 <= pat_b;
            r_cmd2   <= r_cmd1;
            r_odd2   <= r_odd1;
        end
        if (ld3) begin
            r_data3 <= n_data3;
        end
    end
endmodule
